/* src/htw_pkg.sv */
`default_nettype none
package htw_pkg;

  localparam int WHEEL_SLOTS = 1024;          // power of two
  localparam int SLOT_AW     = $clog2(WHEEL_SLOTS);
  localparam int NUM_TIMERS  = 64;
  localparam int EID_W       = $clog2(NUM_TIMERS);
  localparam int CNT_W       = EID_W + 1;
  localparam int ID_W        = 6;
  localparam int PTR_W       = 7;
  localparam int TIME_W      = 64;

  localparam logic [PTR_W-1:0] NIL = 7'h7f;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] KIND_ADD_OK   = 3'd0;
  localparam logic [2:0] KIND_ADD_REJ  = 3'd1;
  localparam logic [2:0] KIND_EXPIRED  = 3'd2;
  localparam logic [2:0] KIND_TICK_NIL = 3'd3;
  localparam logic [2:0] KIND_CANCEL   = 3'd4;

  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic              borrow;
    logic [TIME_W-1:0] diff;
  } sub_rsp_t;

endpackage
`default_nettype wire

/* src/htw_ram.sv */
`default_nettype none
module htw_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/htw_sub.sv */
`default_nettype none
module htw_sub (
  input  wire logic             clk,
  input  wire htw_pkg::sub_req_t req,
  output htw_pkg::sub_rsp_t      rsp
);

  logic [htw_pkg::TIME_W:0] full;

  assign full = {1'b0, req.a} - {1'b0, req.b};

  // shared compare/subtract, result registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      rsp.borrow <= full[htw_pkg::TIME_W];
      rsp.diff   <= full[htw_pkg::TIME_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* src/hashed_timing_wheel_core.sv */
`default_nettype none
// hashed timing wheel: 1024 one-millisecond slots of linked timer lists, 64 timers
// input channel in_*: one transfer is one command (add, tick or cancel)
// output channel out_*: results; out_tlast marks the final result of a command
// add and cancel give one result, a tick gives one result per expired timer
// (slot order, then insertion order) or a single "nothing expired" result
// a sequencer drives one shared 64-bit subtractor and simple dual-port memories
// add checks the times then appends, cancel unlinks, op code 3 is dropped with no result
// a tick walks each scanned slot and collects its listed timers, then takes
// each one in turn and either reports it expired or re-adds it
// in_tready is high only while the sequencer is idle
// results leave through an output register, in the cycle after the sequencer
// produces them; when the receiver stalls the sequencer waits at its next
// result and holds everything else
// after reset the slot memories are swept to empty, with in_tready low
module hashed_timing_wheel_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // op[1:0], timer_id[7:2], expire_ms[71:8], now_ms[135:72]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,  // kind[2:0], expired_id[8:3], zero fill
  output logic              out_tlast   // last
);

  localparam int AW  = htw_pkg::SLOT_AW;
  localparam int EW  = htw_pkg::EID_W;
  localparam int CW  = htw_pkg::CNT_W;
  localparam int PW  = htw_pkg::PTR_W;
  localparam int TW  = htw_pkg::TIME_W;

  typedef enum logic [22:0] {
    S_CLR   = 23'h000001,
    S_IDLE  = 23'h000002,
    S_A1    = 23'h000004,
    S_A2    = 23'h000008,
    S_A3    = 23'h000010,
    S_A4    = 23'h000020,
    S_T1    = 23'h000040,
    S_T2    = 23'h000080,
    S_SCAN0 = 23'h000100,
    S_SCAN1 = 23'h000200,
    S_TFIN  = 23'h000400,
    S_PROC0 = 23'h000800,
    S_PROC1 = 23'h001000,
    S_PROC2 = 23'h002000,
    S_PROC3 = 23'h004000,
    S_PROC4 = 23'h008000,
    S_EXP   = 23'h010000,
    S_AP0   = 23'h020000,
    S_AP1   = 23'h040000,
    S_AP2   = 23'h080000,
    S_CAN0  = 23'h100000,
    S_CAN1  = 23'h200000,
    S_EMIT  = 23'h400000
  } state_t;

  // tick_end_r selects the tick-end result in S_EMIT
  state_t state_r, state_nxt;

  // latched command
  logic [5:0]    id_r, id_nxt;
  logic [TW-1:0] exp_r, exp_nxt;
  logic [TW-1:0] now_r, now_nxt;

  // wheel state
  logic [TW-1:0]               last_r, last_nxt;
  logic [AW-1:0]               start_r, start_nxt;
  logic [htw_pkg::NUM_TIMERS-1:0] linked_r, linked_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;

  // sequencer working registers
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW:0]   i_r, i_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          walk_head_r, walk_head_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [TW-1:0] exp_cur_r, exp_cur_nxt;
  logic          ap_add_r, ap_add_nxt;
  logic [EW-1:0] ap_id_r, ap_id_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [EW-1:0] pend_id_r, pend_id_nxt;
  logic          tick_end_r, tick_end_nxt;
  logic [2:0]    res_kind_r, res_kind_nxt;
  logic [5:0]    res_id_r, res_id_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [5:0] out_id_r, out_id_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  // shared subtractor
  htw_pkg::sub_req_t sub_req;
  htw_pkg::sub_rsp_t sub_rsp;

  // memory ports
  logic          head_we, tail_we, next_we, prev_we, eslot_we, expiry_we, taken_we;
  logic [AW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [PW-1:0] head_wdata, head_rdata, tail_wdata, tail_rdata;
  logic [EW-1:0] next_waddr, next_raddr, prev_waddr, prev_raddr;
  logic [PW-1:0] next_wdata, next_rdata, prev_wdata, prev_rdata;
  logic [EW-1:0] eslot_waddr, eslot_raddr;
  logic [AW-1:0] eslot_wdata, eslot_rdata;
  logic [EW-1:0] expiry_waddr, expiry_raddr;
  logic [TW-1:0] expiry_wdata, expiry_rdata;
  logic [EW-1:0] taken_waddr, taken_raddr;
  logic [EW-1:0] taken_wdata, taken_rdata;

  logic          in_xfer;
  logic [AW-1:0] s_scan;
  logic [PW-1:0] cur_e;
  logic          cur_valid;
  logic          id_ok;
  logic [EW-1:0] id_e;
  logic          t_valid, p_valid, n_valid;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_id_r, out_kind_r};
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  assign s_scan    = start_r + i_r[AW-1:0];
  assign cur_e     = walk_head_r ? head_rdata : next_rdata;
  assign cur_valid = cur_e < PW'(htw_pkg::NUM_TIMERS);
  assign id_ok     = {1'b0, id_r} < PW'(htw_pkg::NUM_TIMERS);
  assign id_e      = id_r[EW-1:0];
  assign t_valid   = tail_rdata < PW'(htw_pkg::NUM_TIMERS);
  assign p_valid   = prev_rdata < PW'(htw_pkg::NUM_TIMERS);
  assign n_valid   = next_rdata < PW'(htw_pkg::NUM_TIMERS);

  htw_sub u_sub (.clk(clk), .req(sub_req), .rsp(sub_rsp));

  htw_ram #(.DEPTH(htw_pkg::WHEEL_SLOTS), .WIDTH(PW)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  htw_ram #(.DEPTH(htw_pkg::WHEEL_SLOTS), .WIDTH(PW)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rdata));
  htw_ram #(.DEPTH(htw_pkg::NUM_TIMERS), .WIDTH(PW)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata));
  htw_ram #(.DEPTH(htw_pkg::NUM_TIMERS), .WIDTH(PW)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_rdata));
  htw_ram #(.DEPTH(htw_pkg::NUM_TIMERS), .WIDTH(AW)) u_eslot (
    .clk(clk), .we(eslot_we), .waddr(eslot_waddr), .wdata(eslot_wdata),
    .raddr(eslot_raddr), .rdata(eslot_rdata));
  htw_ram #(.DEPTH(htw_pkg::NUM_TIMERS), .WIDTH(TW)) u_expiry (
    .clk(clk), .we(expiry_we), .waddr(expiry_waddr), .wdata(expiry_wdata),
    .raddr(expiry_raddr), .rdata(expiry_rdata));
  htw_ram #(.DEPTH(htw_pkg::NUM_TIMERS), .WIDTH(EW)) u_taken (
    .clk(clk), .we(taken_we), .waddr(taken_waddr), .wdata(taken_wdata),
    .raddr(taken_raddr), .rdata(taken_rdata));

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    exp_nxt       = exp_r;
    now_nxt       = now_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    linked_nxt    = linked_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    walk_head_nxt = walk_head_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    exp_cur_nxt   = exp_cur_r;
    ap_add_nxt    = ap_add_r;
    ap_id_nxt     = ap_id_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    tick_end_nxt  = tick_end_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;

    sub_req = '{en: 1'b0, a: now_r, b: last_r};

    head_we = 1'b0;  head_waddr = s_scan;  head_wdata = htw_pkg::NIL;  head_raddr = s_scan;
    tail_we = 1'b0;  tail_waddr = s_scan;  tail_wdata = htw_pkg::NIL;  tail_raddr = s_r;
    next_we = 1'b0;  next_waddr = ap_id_r; next_wdata = htw_pkg::NIL;
    next_raddr = cur_e[EW-1:0];
    prev_we = 1'b0;  prev_waddr = ap_id_r; prev_wdata = htw_pkg::NIL;  prev_raddr = id_e;
    eslot_we = 1'b0; eslot_waddr = ap_id_r; eslot_wdata = s_r;         eslot_raddr = id_e;
    expiry_we = 1'b0; expiry_waddr = ap_id_r; expiry_wdata = exp_r;
    expiry_raddr = taken_rdata;
    taken_we = 1'b0; taken_waddr = n_r[EW-1:0]; taken_wdata = cur_e[EW-1:0];
    taken_raddr = j_r[EW-1:0];

    case (state_r)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        tail_we    = 1'b1;
        tail_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          id_nxt  = in_tdata[7:2];
          exp_nxt = in_tdata[71:8];
          now_nxt = in_tdata[135:72];
          // first add or tick starts the wheel
          if (last_r == '0 && (in_tdata[1:0] == htw_pkg::OP_ADD ||
                               in_tdata[1:0] == htw_pkg::OP_TICK)) begin
            last_nxt  = in_tdata[135:72];
            start_nxt = '0;
          end
          case (in_tdata[1:0])
            htw_pkg::OP_ADD:    state_nxt = S_A1;
            htw_pkg::OP_TICK:   state_nxt = S_T1;
            htw_pkg::OP_CANCEL: state_nxt = S_CAN0;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      // add: now before last take time?
      S_A1: begin
        sub_req   = '{en: 1'b1, a: now_r, b: last_r};
        state_nxt = S_A2;
      end

      // add: expiry already past?
      S_A2: begin
        res_id_nxt = id_r;
        if (sub_rsp.borrow || !id_ok) begin
          res_kind_nxt = htw_pkg::KIND_ADD_REJ;
          tick_end_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else begin
          sub_req   = '{en: 1'b1, a: exp_r, b: now_r};
          state_nxt = S_A3;
        end
      end

      S_A3: begin
        tick_end_nxt = 1'b0;
        if (sub_rsp.borrow) begin
          res_kind_nxt = htw_pkg::KIND_ADD_REJ;
          state_nxt    = S_EMIT;
        end else if (linked_r[id_e]) begin
          res_kind_nxt = htw_pkg::KIND_ADD_OK;
          state_nxt    = S_EMIT;
        end else begin
          sub_req   = '{en: 1'b1, a: exp_r, b: last_r};
          state_nxt = S_A4;
        end
      end

      S_A4: begin
        s_nxt        = start_r + sub_rsp.diff[AW-1:0];
        ap_add_nxt   = 1'b1;
        ap_id_nxt    = id_e;
        res_kind_nxt = htw_pkg::KIND_ADD_OK;
        state_nxt    = S_AP0;
      end

      // append ap_id_r to slot s_r
      S_AP0: begin
        state_nxt = S_AP1;
      end

      S_AP1: begin
        tail_we     = 1'b1;
        tail_waddr  = s_r;
        tail_wdata  = PW'(ap_id_r);
        eslot_we    = 1'b1;
        prev_we     = 1'b1;
        prev_wdata  = t_valid ? tail_rdata : htw_pkg::NIL;
        expiry_we   = ap_add_r;
        if (t_valid) begin
          next_we    = 1'b1;
          next_waddr = tail_rdata[EW-1:0];
          next_wdata = PW'(ap_id_r);
        end else begin
          head_we    = 1'b1;
          head_waddr = s_r;
          head_wdata = PW'(ap_id_r);
        end
        state_nxt = S_AP2;
      end

      S_AP2: begin
        next_we             = 1'b1;
        linked_nxt[ap_id_r] = 1'b1;
        if (ap_add_r) begin
          tick_end_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PROC0;
        end
      end

      // cancel: fetch links of the entry
      S_CAN0: begin
        next_raddr   = id_e;
        res_kind_nxt = htw_pkg::KIND_CANCEL;
        res_id_nxt   = id_r;
        tick_end_nxt = 1'b0;
        if (id_ok && linked_r[id_e]) begin
          state_nxt = S_CAN1;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_CAN1: begin
        if (p_valid) begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[EW-1:0];
          next_wdata = next_rdata;
        end else begin
          head_we    = 1'b1;
          head_waddr = eslot_rdata;
          head_wdata = next_rdata;
        end
        if (n_valid) begin
          prev_we    = 1'b1;
          prev_waddr = next_rdata[EW-1:0];
          prev_wdata = prev_rdata;
        end else begin
          tail_we    = 1'b1;
          tail_waddr = eslot_rdata;
          tail_wdata = prev_rdata;
        end
        linked_nxt[id_e] = 1'b0;
        state_nxt        = S_EMIT;
      end

      // tick: backwards?
      S_T1: begin
        sub_req   = '{en: 1'b1, a: now_r, b: last_r};
        state_nxt = S_T2;
      end

      S_T2: begin
        if (sub_rsp.borrow) begin
          res_kind_nxt = htw_pkg::KIND_TICK_NIL;
          res_id_nxt   = '0;
          tick_end_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else begin
          // scan count limited to one full turn
          if (sub_rsp.diff >= TW'(htw_pkg::WHEEL_SLOTS - 1)) begin
            cnt_nxt = (AW+1)'(htw_pkg::WHEEL_SLOTS);
          end else begin
            cnt_nxt = sub_rsp.diff[AW:0] + 1'b1;
          end
          i_nxt     = '0;
          n_nxt     = '0;
          state_nxt = S_SCAN0;
        end
      end

      S_SCAN0: begin
        walk_head_nxt = 1'b1;
        if (i_r == cnt_r) begin
          state_nxt = S_TFIN;
        end else begin
          state_nxt = S_SCAN1;
        end
      end

      // walk one slot list, collecting entries
      S_SCAN1: begin
        if (cur_valid && n_r != CW'(htw_pkg::NUM_TIMERS)) begin
          taken_we                   = 1'b1;
          n_nxt                      = n_r + 1'b1;
          linked_nxt[cur_e[EW-1:0]]  = 1'b0;
          walk_head_nxt              = 1'b0;
        end else begin
          head_we   = 1'b1;
          tail_we   = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN0;
        end
      end

      S_TFIN: begin
        last_nxt    = now_r;
        start_nxt   = start_r + AW'(cnt_r - 1'b1);
        j_nxt       = '0;
        pend_v_nxt  = 1'b0;
        state_nxt   = S_PROC0;
      end

      S_PROC0: begin
        if (j_r == n_r) begin
          tick_end_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_PROC1;
        end
      end

      S_PROC1: begin
        e_nxt     = taken_rdata;
        state_nxt = S_PROC2;
      end

      S_PROC2: begin
        exp_cur_nxt = expiry_rdata;
        sub_req     = '{en: 1'b1, a: now_r, b: expiry_rdata};
        state_nxt   = S_PROC3;
      end

      // borrow means not yet due: re-add
      S_PROC3: begin
        if (sub_rsp.borrow) begin
          if (last_r == '0) begin
            start_nxt = '0;
          end
          sub_req   = '{en: 1'b1, a: exp_cur_r, b: last_r};
          state_nxt = S_PROC4;
        end else begin
          state_nxt = S_EXP;
        end
      end

      S_PROC4: begin
        s_nxt      = start_r + sub_rsp.diff[AW-1:0];
        ap_add_nxt = 1'b0;
        ap_id_nxt  = e_r;
        state_nxt  = S_AP0;
      end

      // expired: hold one back so the final one carries last
      S_EXP: begin
        if (!pend_v_r) begin
          pend_v_nxt  = 1'b1;
          pend_id_nxt = e_r;
          j_nxt       = j_r + 1'b1;
          state_nxt   = S_PROC0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = htw_pkg::KIND_EXPIRED;
          out_id_nxt    = 6'(pend_id_r);
          out_last_nxt  = 1'b0;
          pend_id_nxt   = e_r;
          j_nxt         = j_r + 1'b1;
          state_nxt     = S_PROC0;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (tick_end_r && pend_v_r) begin
            out_kind_nxt = htw_pkg::KIND_EXPIRED;
            out_id_nxt   = 6'(pend_id_r);
          end else if (tick_end_r) begin
            out_kind_nxt = htw_pkg::KIND_TICK_NIL;
            out_id_nxt   = '0;
          end else begin
            out_kind_nxt = res_kind_r;
            out_id_nxt   = res_id_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      last_r      <= '0;
      start_r     <= '0;
      linked_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      tick_end_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      start_r     <= start_nxt;
      linked_r    <= linked_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      tick_end_r  <= tick_end_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    exp_r       <= exp_nxt;
    now_r       <= now_nxt;
    cnt_r       <= cnt_nxt;
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    walk_head_r <= walk_head_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    exp_cur_r   <= exp_cur_nxt;
    ap_add_r    <= ap_add_nxt;
    ap_id_r     <= ap_id_nxt;
    pend_id_r   <= pend_id_nxt;
    res_kind_r  <= res_kind_nxt;
    res_id_r    <= res_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
`default_nettype wire

/* src/htw_checker.sv */
`default_nettype none
module htw_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [135:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [15:0]  out_tdata,
  input wire logic         out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a real command keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] != htw_pkg::OP_NONE |=> !in_tready)
    else $error("block ready right after a command");

  // add, cancel and empty tick give a single result
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == htw_pkg::KIND_ADD_OK ||
                   out_tdata[2:0] == htw_pkg::KIND_ADD_REJ ||
                   out_tdata[2:0] == htw_pkg::KIND_TICK_NIL ||
                   out_tdata[2:0] == htw_pkg::KIND_CANCEL) |-> out_tlast)
    else $error("single result without last");

  // empty tick reports id zero, fill bits zero
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0 &&
      (out_tdata[2:0] != htw_pkg::KIND_TICK_NIL || out_tdata[8:3] == 6'd0))
    else $error("bad result fill");

endmodule

bind hashed_timing_wheel_core htw_checker u_htw_checker (.*);
`default_nettype wire

/* tb/tb_hashed_timing_wheel_core.sv */
`default_nettype none
module tb_hashed_timing_wheel_core;

  localparam int LIMIT_CYCLES = 2000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;   // op, timer_id, expire_ms, now_ms
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;       // kind, expired_id, zero fill
  logic         out_tlast;

  always #10 clk = ~clk;

  hashed_timing_wheel_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] id;
    logic       last;
  } wheel_result_t;

  // shadow copy of the wheel
  logic [htw_pkg::PTR_W-1:0]   sh_head [htw_pkg::WHEEL_SLOTS];
  logic [htw_pkg::PTR_W-1:0]   sh_tail [htw_pkg::WHEEL_SLOTS];
  logic [htw_pkg::PTR_W-1:0]   sh_next [htw_pkg::NUM_TIMERS];
  logic [htw_pkg::PTR_W-1:0]   sh_prev [htw_pkg::NUM_TIMERS];
  logic                        sh_linked [htw_pkg::NUM_TIMERS];
  logic [htw_pkg::SLOT_AW-1:0] sh_slot [htw_pkg::NUM_TIMERS];
  logic [63:0]                 sh_expiry [htw_pkg::NUM_TIMERS];
  logic [63:0]                 sh_last_take;
  logic [htw_pkg::SLOT_AW-1:0] sh_start;

  wheel_result_t pending_results[$];
  int  error_count = 0;
  int  result_count = 0;
  int  expired_count = 0;
  int  cycle_count = 0;

  // long receiver hold-off request, served by the sink process
  bit  hold_request = 1'b0;
  bit  quiet_mode = 1'b0;

  function automatic void queue_result(input logic [2:0] kind, input logic [5:0] id,
                                       input logic last);
    wheel_result_t r;
    r.kind = kind;
    r.id   = id;
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic wheel_clear();
    for (int i = 0; i < htw_pkg::WHEEL_SLOTS; i++) begin
      sh_head[i] = htw_pkg::NIL;
      sh_tail[i] = htw_pkg::NIL;
    end
    for (int i = 0; i < htw_pkg::NUM_TIMERS; i++) begin
      sh_linked[i] = 1'b0;
      sh_next[i] = htw_pkg::NIL;
      sh_prev[i] = htw_pkg::NIL;
      sh_slot[i] = '0;
      sh_expiry[i] = '0;
    end
    sh_last_take = '0;
    sh_start = '0;
  endtask

  function automatic void wheel_append(input logic [5:0] id,
                                       input logic [htw_pkg::SLOT_AW-1:0] s);
    logic [htw_pkg::PTR_W-1:0] t;
    if (sh_linked[id]) return;
    t = sh_tail[s];
    if (t != htw_pkg::NIL) begin
      sh_next[t[5:0]] = {1'b0, id};
      sh_prev[id] = t;
    end else begin
      sh_head[s] = {1'b0, id};
      sh_prev[id] = htw_pkg::NIL;
    end
    sh_next[id] = htw_pkg::NIL;
    sh_tail[s] = {1'b0, id};
    sh_slot[id] = s;
    sh_linked[id] = 1'b1;
  endfunction

  task automatic wheel_unlink(input logic [5:0] id);
    logic [htw_pkg::PTR_W-1:0] p, n;
    logic [htw_pkg::SLOT_AW-1:0] s;
    if (!sh_linked[id]) return;
    s = sh_slot[id];
    p = sh_prev[id];
    n = sh_next[id];
    if (p != htw_pkg::NIL) sh_next[p[5:0]] = n; else sh_head[s] = n;
    if (n != htw_pkg::NIL) sh_prev[n[5:0]] = p; else sh_tail[s] = p;
    sh_next[id] = htw_pkg::NIL;
    sh_prev[id] = htw_pkg::NIL;
    sh_linked[id] = 1'b0;
  endtask

  function automatic bit wheel_add(input logic [5:0] id, input logic [63:0] expiry,
                                   input logic [63:0] now);
    logic [63:0] diff;
    if (sh_last_take == 0) begin
      sh_last_take = now;
      sh_start = '0;
    end
    if (now < sh_last_take || expiry < now) return 1'b0;
    if (sh_linked[id]) return 1'b1;
    diff = expiry - sh_last_take;
    sh_expiry[id] = expiry;
    wheel_append(id, sh_start + diff[htw_pkg::SLOT_AW-1:0]);
    return 1'b1;
  endfunction

  // works out the results of one command and queues them
  task automatic predict_command(input logic [1:0] op, input logic [5:0] id,
                                 input logic [63:0] expiry, input logic [63:0] now);
    logic [5:0]  taken[$];
    logic [63:0] d, scan;
    logic [htw_pkg::PTR_W-1:0] e;
    logic [htw_pkg::SLOT_AW-1:0] s;
    int k;
    case (op)
      htw_pkg::OP_ADD: begin
        queue_result(wheel_add(id, expiry, now) ? htw_pkg::KIND_ADD_OK : htw_pkg::KIND_ADD_REJ,
                     id, 1'b1);
      end
      htw_pkg::OP_CANCEL: begin
        wheel_unlink(id);
        queue_result(htw_pkg::KIND_CANCEL, id, 1'b1);
      end
      htw_pkg::OP_TICK: begin
        if (sh_last_take == 0) begin
          sh_last_take = now;
          sh_start = '0;
        end
        if (now < sh_last_take) begin
          queue_result(htw_pkg::KIND_TICK_NIL, 6'd0, 1'b1);
          return;
        end
        d = now - sh_last_take;
        scan = (d >= htw_pkg::WHEEL_SLOTS - 1) ? htw_pkg::WHEEL_SLOTS : d + 1;
        for (int i = 0; i < scan; i++) begin
          s = sh_start + htw_pkg::SLOT_AW'(i);
          e = sh_head[s];
          while (e != htw_pkg::NIL && taken.size() < htw_pkg::NUM_TIMERS) begin
            taken.insert(taken.size(), e[5:0]);
            sh_linked[e[5:0]] = 1'b0;
            e = sh_next[e[5:0]];
          end
          sh_head[s] = htw_pkg::NIL;
          sh_tail[s] = htw_pkg::NIL;
        end
        sh_last_take = now;
        sh_start = sh_start + htw_pkg::SLOT_AW'(scan - 1);
        k = 0;
        foreach (taken[j]) begin
          if (now < sh_expiry[taken[j]] && wheel_add(taken[j], sh_expiry[taken[j]], now))
            continue;
          queue_result(htw_pkg::KIND_EXPIRED, taken[j], 1'b0);
          k++;
        end
        if (k == 0) queue_result(htw_pkg::KIND_TICK_NIL, 6'd0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
      default: ;   // unused op code, dropped
    endcase
  endtask

  // one command transfer; tvalid stays high into the next command unless a gap follows
  task automatic send_command(input logic [1:0] op, input logic [5:0] id,
                              input logic [63:0] expiry, input logic [63:0] now,
                              input bit gaps);
    if (gaps && !quiet_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, expiry, id, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(op, id, expiry, now);
  endtask

  // sink: random stalls, plus one long hold-off on request
  initial begin
    wheel_result_t want, got;
    int hold_cycles;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_cycles = 0;
        out_tready <= 1'b0;
        while (hold_cycles < 400) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_request = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[2:0], out_tdata[8:3], out_tlast};
        result_count++;
        if (got.kind == htw_pkg::KIND_EXPIRED) expired_count++;
        if (pending_results.size() == 0) begin
          $error("unexpected result kind=%0d id=%0d", got.kind, got.id);
          error_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            error_count++;
          end
          if (got.id !== want.id) begin
            $error("expired_id: expected %0d actual %0d", want.id, got.id);
            error_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed table: op, id, expiry, now, and expected kind of the last result
  typedef struct {
    logic [1:0]  op;
    logic [5:0]  id;
    logic [63:0] expiry;
    logic [63:0] now;
    int          want_kind;   // -1 means take the predictor's word only
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{htw_pkg::OP_CANCEL, 6'd63, 64'd0,   64'd0,   4},    // cancel of unlisted entry
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd100, 3},    // first tick starts the wheel
    '{htw_pkg::OP_ADD,    6'd0,  64'd99,  64'd100, 1},    // expiry already past
    '{htw_pkg::OP_ADD,    6'd1,  64'd150, 64'd50,  1},    // now before last take time
    '{htw_pkg::OP_ADD,    6'd0,  64'd100, 64'd100, 0},
    '{htw_pkg::OP_ADD,    6'd63, 64'd105, 64'd100, 0},
    '{htw_pkg::OP_ADD,    6'd2,  64'd105, 64'd100, 0},
    '{htw_pkg::OP_ADD,    6'd2,  64'd900, 64'd100, 0},    // already listed, ignored
    '{htw_pkg::OP_ADD,    6'd5,  64'd2000, 64'd100, 0},   // wraps around the wheel
    '{htw_pkg::OP_ADD,    6'd6,  64'hffff_ffff_ffff_ffff, 64'd100, 0},
    '{htw_pkg::OP_ADD,    6'd7,  64'd110, 64'd100, 0},
    '{htw_pkg::OP_CANCEL, 6'd7,  64'd0,   64'd0,   4},
    '{htw_pkg::OP_NONE,   6'd9,  64'd0,   64'd0,   -1},   // dropped op code
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd90,  3},    // tick backwards
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd100, -1},
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd106, -1},
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd1300, -1},  // long gap, re-add of wrapped
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'd2100, -1},
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'hffff_ffff_ffff_fff0, -1},
    '{htw_pkg::OP_ADD,    6'd10, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0},
    '{htw_pkg::OP_TICK,   6'd0,  64'd0,   64'hffff_ffff_ffff_ffff, -1}
  };

  initial begin
    logic [63:0] now, exp;
    logic [1:0]  op;
    logic [5:0]  id;
    int          n_items, tail_wait;
    wheel_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_command(directed_rows[r].op, directed_rows[r].id, directed_rows[r].expiry,
                   directed_rows[r].now, 1'b1);
      if (directed_rows[r].want_kind >= 0 &&
          (pending_results.size() == 0 ||
           pending_results[$].kind != 3'(directed_rows[r].want_kind))) begin
        $error("kind: expected %0d in row %0d, predictor disagrees", directed_rows[r].want_kind, r);
        error_count++;
      end
    end

    // wheel time is now at the top of the range: empty it with cancels
    for (int i = 0; i < htw_pkg::NUM_TIMERS; i++)
      send_command(htw_pkg::OP_CANCEL, 6'(i), 0, 0, 1'b0);

    // random part: time stays at the top of the range, adds due at once,
    // ticks collect them; some commands carry stale time or past expiry
    now = 64'hffff_ffff_ffff_ffff;
    n_items = 0;
    while (n_items < 85) begin
      if (n_items == 30) hold_request = 1'b1;
      if (n_items >= 70) quiet_mode = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          op = htw_pkg::OP_ADD;
          id = 6'($urandom_range(0, 63));
          exp = now;
        end
        5, 6: begin op = htw_pkg::OP_CANCEL; id = 6'($urandom); exp = {$urandom, $urandom}; end
        7: begin op = htw_pkg::OP_NONE; id = 6'($urandom); exp = {$urandom, $urandom}; end
        default: begin
          op = htw_pkg::OP_TICK; id = 6'($urandom); exp = {$urandom, $urandom};
        end
      endcase
      if ($urandom_range(0, 9) == 0)
        send_command(op, id, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      else
        send_command(op, id, exp, now, 1'b1);
      n_items++;
    end
    in_tvalid <= 1'b0;

    tail_wait = 0;
    while (pending_results.size() != 0) @(posedge clk);
    while (tail_wait < 3000) begin
      @(posedge clk);
      tail_wait++;
    end
    $display("covered %0d random commands after the directed table, %0d results, %0d expiries",
             n_items, result_count, expired_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
src/htw_pkg.sv
src/htw_ram.sv
src/htw_sub.sv
src/hashed_timing_wheel_core.sv
src/htw_checker.sv
tb/tb_hashed_timing_wheel_core.sv
